// ===== hdl/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg: shared types and helpers for the vertex skinner
// Beat layouts, operation codes, table write command and saturation.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int MaxBonesDef = 64;
  localparam int SlotsDef    = 4;
  localparam int BoneW       = 8;
  localparam int EntryW      = 4;
  localparam int Elems       = 16;
  localparam logic [BoneW-1:0] BoneNone = 8'hFF;
  localparam logic signed [31:0] QOne = 32'sd65536;
  // weighted term: 32 x 17 bit product shifted right by 15
  localparam int WpW = 34;

  typedef enum logic [1:0] {
    OpPose = 2'd0,
    OpBind = 2'd1,
    OpSkin = 2'd2,
    OpRsvd = 2'd3   // unused code, dropped without a result
  } lbs_op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        bone_slots;
    logic [63:0]        slot_weights;
    logic [5:0]         matrix_bone;
    logic [3:0]         matrix_entry;
    logic signed [31:0] matrix_value;
  } lbs_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } lbs_out_t;

  // table write command broadcast to every lane
  typedef struct packed {
    logic               en;
    logic               sel_bind;
    logic [BoneW-1:0]   bone;
    logic [EntryW-1:0]  entry;
    logic signed [31:0] value;
  } lbs_wr_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/lbs_lane.sv =====
// ----------------------------------------------------------------------------
// lbs_lane: one bone slot of the skinner
// Holds its own copy of the pose and bind tables and computes
// ((pose * bind * v) * weight) >> 15 over a six stage pipeline; unknown bones skip the matrices.
// ----------------------------------------------------------------------------
module lbs_lane #(
  parameter int MaxBones = lbs_pkg::MaxBonesDef
) (
  input  logic                        clk_i,
  input  logic                        adv_i,
  input  lbs_pkg::lbs_wr_t            wr_i,
  input  logic [lbs_pkg::BoneW-1:0]   bone_i,
  input  logic [15:0]                 weight_i,
  input  logic signed [31:0]          pos_i [3],
  output logic signed [lbs_pkg::WpW-1:0] wp_o [3]
);
  import lbs_pkg::*;

  localparam int AddrW = (MaxBones > 1) ? $clog2(MaxBones) : 1;

  logic signed [31:0] bind_mem [Elems][MaxBones];
  logic signed [31:0] pose_mem [Elems][MaxBones];

  logic [AddrW-1:0] wa, ra;
  assign wa = wr_i.bone[AddrW-1:0];
  assign ra = bone_i[AddrW-1:0];

  // stage 0 state
  logic signed [31:0] bind0_q [Elems];
  logic signed [31:0] pose0_q [Elems];
  logic signed [31:0] v0_q [4];
  logic [15:0]        w0_q;
  logic               id0_q;
  // stage 1
  logic signed [47:0] bp1_q [Elems];
  logic signed [31:0] pose1_q [Elems];
  logic signed [31:0] v1_q [3];
  logic [15:0]        w1_q;
  logic               id1_q;
  // stage 2
  logic signed [31:0] t2_q [4];
  logic signed [31:0] pose2_q [12];
  logic signed [31:0] v2_q [3];
  logic [15:0]        w2_q;
  logic               id2_q;
  // stage 3
  logic signed [47:0] pp3_q [12];
  logic signed [31:0] v3_q [3];
  logic [15:0]        w3_q;
  logic               id3_q;
  // stage 4
  logic signed [31:0] p4_q [3];
  logic [15:0]        w4_q;
  // stage 5
  logic signed [WpW-1:0] wp5_q [3];

  logic id_now;
  assign id_now = (bone_i == BoneNone) || (32'(bone_i) >= MaxBones);

  // table writes and row reads
  always_ff @(posedge clk_i) begin
    for (int e = 0; e < Elems; e++) begin
      if (wr_i.en && (32'(wr_i.entry) == e)) begin
        if (wr_i.sel_bind) begin
          bind_mem[e][wa] <= wr_i.value;
        end else begin
          pose_mem[e][wa] <= wr_i.value;
        end
      end
    end
    if (adv_i) begin
      for (int e = 0; e < Elems; e++) begin
        bind0_q[e] <= bind_mem[e][ra];
        pose0_q[e] <= pose_mem[e][ra];
      end
      v0_q[0] <= pos_i[0];
      v0_q[1] <= pos_i[1];
      v0_q[2] <= pos_i[2];
      v0_q[3] <= QOne;
      w0_q    <= weight_i;
      id0_q   <= id_now;
    end
  end

  // bind products
  logic signed [63:0] bm [Elems];
  always_comb begin
    for (int e = 0; e < Elems; e++) begin
      bm[e] = bind0_q[e] * v0_q[e % 4];
    end
  end

  // pose products
  logic signed [63:0] pm [12];
  always_comb begin
    for (int e = 0; e < 12; e++) begin
      pm[e] = pose2_q[e] * t2_q[e % 4];
    end
  end

  // row sums
  logic signed [49:0] tsum [4];
  logic signed [49:0] psum [3];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      tsum[i] = 50'(bp1_q[4*i]) + 50'(bp1_q[4*i+1])
              + 50'(bp1_q[4*i+2]) + 50'(bp1_q[4*i+3]);
    end
    for (int i = 0; i < 3; i++) begin
      psum[i] = 50'(pp3_q[4*i]) + 50'(pp3_q[4*i+1])
              + 50'(pp3_q[4*i+2]) + 50'(pp3_q[4*i+3]);
    end
  end

  // weight products
  logic signed [48:0] wm [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      wm[a] = p4_q[a] * $signed({1'b0, w4_q});
    end
  end

  // pipeline stages 1 to 5
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int e = 0; e < Elems; e++) begin
        bp1_q[e]   <= bm[e][63:16];
        pose1_q[e] <= pose0_q[e];
      end
      for (int a = 0; a < 3; a++) begin
        v1_q[a] <= v0_q[a];
        v2_q[a] <= v1_q[a];
        v3_q[a] <= v2_q[a];
      end
      w1_q  <= w0_q;
      id1_q <= id0_q;

      for (int i = 0; i < 4; i++) begin
        t2_q[i] <= sat32(64'(tsum[i]));
      end
      for (int e = 0; e < 12; e++) begin
        pose2_q[e] <= pose1_q[e];
        pp3_q[e]   <= pm[e][63:16];
      end
      w2_q  <= w1_q;
      id2_q <= id1_q;
      w3_q  <= w2_q;
      id3_q <= id2_q;

      for (int a = 0; a < 3; a++) begin
        p4_q[a]  <= id3_q ? v3_q[a] : sat32(64'(psum[a]));
        wp5_q[a] <= wm[a][48:15];
      end
      w4_q <= w3_q;
    end
  end

  assign wp_o = wp5_q;

endmodule

// ===== hdl/lbs_merge.sv =====
// ----------------------------------------------------------------------------
// lbs_merge: slot merge
// Sums the weighted terms of all lanes per axis and saturates to 32 bits.
// ----------------------------------------------------------------------------
module lbs_merge #(
  parameter int NumSlots = lbs_pkg::SlotsDef
) (
  input  logic                           clk_i,
  input  logic                           adv_i,
  input  logic signed [lbs_pkg::WpW-1:0] wp_i [NumSlots][3],
  output lbs_pkg::lbs_out_t              out_o
);
  import lbs_pkg::*;

  logic signed [WpW+1:0] sum [3];
  lbs_out_t out_q;

  // per axis adder over lanes
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a] = '0;
      for (int s = 0; s < NumSlots; s++) begin
        sum[a] = sum[a] + (WpW+2)'(wp_i[s][a]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q.out_x <= sat32(64'(sum[0]));
      out_q.out_y <= sat32(64'(sum[1]));
      out_q.out_z <= sat32(64'(sum[2]));
    end
  end

  assign out_o = out_q;

endmodule

// ===== hdl/linear_blend_vertex_skinner.sv =====
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinner: four bone linear blend skinning engine
// Each input beat writes one element of a bone's pose or bind matrix, skins one
// vertex or is dropped (reserved code); skin beats return one output beat each.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o/in_data_i carries one operation per
//   beat. Pose and bind writes take effect for any skin beat accepted later
//   and produce no output beat. Skin beats return the blended position on
//   out_valid_o/out_ready_i/out_data_o in order.
//   Pipeline: a skin beat passes seven register stages (one table read, two
//   multiply/sum steps per matrix, one weight multiply, one lane merge)
//   before it reaches the output. Throughput is one beat per cycle while the
//   output is not stalled; every slot has its own lane with private table
//   copies, so all four matrix pairs are read in the same cycle.
//   The whole pipeline advances together; when the output holds a beat that
//   is not taken, in_ready_o drops and the pipeline freezes.
//   Reset clears all valid flags; the matrix tables are not cleared and must
//   be written before a skin beat uses them.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinner #(
  parameter int MaxBones = lbs_pkg::MaxBonesDef,
  parameter int NumSlots = lbs_pkg::SlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lbs_pkg::lbs_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lbs_pkg::lbs_out_t   out_data_o
);
  import lbs_pkg::*;

  localparam int Lat = 7;

  logic [Lat-1:0] vld_q;
  logic adv, acc;
  lbs_wr_t wr;

  assign adv        = !vld_q[Lat-1] || out_ready_i;
  assign in_ready_o = adv;
  assign acc        = in_valid_i && adv;

  // table write command
  assign wr.en       = acc && ((in_data_i.operation == OpPose) ||
                               (in_data_i.operation == OpBind)) &&
                       (32'(in_data_i.matrix_bone) < MaxBones);
  assign wr.sel_bind = (in_data_i.operation == OpBind);
  assign wr.bone     = BoneW'(in_data_i.matrix_bone);
  assign wr.entry    = in_data_i.matrix_entry;
  assign wr.value    = in_data_i.matrix_value;

  // valid track of skin beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], acc && (in_data_i.operation == OpSkin)};
    end
  end

  logic signed [31:0] pos [3];
  assign pos[0] = in_data_i.pos_x;
  assign pos[1] = in_data_i.pos_y;
  assign pos[2] = in_data_i.pos_z;

  logic signed [WpW-1:0] wp [NumSlots][3];

  for (genvar s = 0; s < NumSlots; s++) begin : g_lane
    lbs_lane #(
      .MaxBones (MaxBones)
    ) u_lane (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .wr_i     (wr),
      .bone_i   (in_data_i.bone_slots[8*s +: 8]),
      .weight_i (in_data_i.slot_weights[16*s +: 16]),
      .pos_i    (pos),
      .wp_o     (wp[s])
    );
  end

  lbs_merge #(
    .NumSlots (NumSlots)
  ) u_merge (
    .clk_i (clk_i),
    .adv_i (adv),
    .wp_i  (wp),
    .out_o (out_data_o)
  );

  assign out_valid_o = vld_q[Lat-1];

endmodule

// ===== dv/tb_linear_blend_vertex_skinner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_blend_vertex_skinner: self-checking bench for the vertex skinner
// Loads the pose and bind tables, walks a short table of directed beats, then
// streams random writes, skins and reserved beats under varying back pressure.
// Every skin is predicted from a private copy of the tables and checked in order.
// ----------------------------------------------------------------------------
module tb_linear_blend_vertex_skinner;
  import lbs_pkg::*;

  localparam int NumBones = 64;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  lbs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lbs_out_t out_data;

  linear_blend_vertex_skinner DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // predictor state: table copies and a per-bone mask of written elements
  logic signed [31:0] pose_q [NumBones*16];
  logic signed [31:0] bind_q [NumBones*16];
  logic [31:0]        written [NumBones];
  lbs_out_t           skin_q [$];
  int                 errors = 0;
  int                 tx_idle = 9;
  int                 rx_idle = 54;
  int                 phase = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // pose * bind * (x,y,z,1), weighted per slot and summed; unknown bones skip the matrices
  function automatic lbs_out_t blend_vertex(lbs_in_t d);
    longint v[4], t[4], p[3], acc;
    longint sum[3];
    int unsigned bone, base;
    longint w;
    lbs_out_t r;
    v[0] = d.pos_x; v[1] = d.pos_y; v[2] = d.pos_z; v[3] = 65536;
    sum = '{0, 0, 0};
    for (int s = 0; s < 4; s++) begin
      bone = d.bone_slots[8*s +: 8];
      w = longint'(d.slot_weights[16*s +: 16]);
      if (bone >= NumBones) begin
        p[0] = v[0]; p[1] = v[1]; p[2] = v[2];
      end else begin
        base = bone * 16;
        for (int i = 0; i < 4; i++) begin
          acc = 0;
          for (int c = 0; c < 4; c++) acc += (longint'(bind_q[base+i*4+c]) * v[c]) >>> 16;
          t[i] = sat_q(acc);
        end
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int c = 0; c < 4; c++) acc += (longint'(pose_q[base+i*4+c]) * t[c]) >>> 16;
          p[i] = sat_q(acc);
        end
      end
      for (int a = 0; a < 3; a++) sum[a] += (p[a] * w) >>> 15;
    end
    r.out_x = 32'(sat_q(sum[0]));
    r.out_y = 32'(sat_q(sum[1]));
    r.out_z = 32'(sat_q(sum[2]));
    return r;
  endfunction

  // update the model at acceptance; queue the expected skin result
  function automatic void accept_beat(lbs_in_t d);
    int unsigned idx;
    idx = d.matrix_bone * 16 + d.matrix_entry;
    case (d.operation)
      OpPose: begin
        pose_q[idx] = d.matrix_value;
        written[d.matrix_bone][d.matrix_entry] = 1'b1;
      end
      OpBind: begin
        bind_q[idx] = d.matrix_value;
        written[d.matrix_bone][16 + d.matrix_entry] = 1'b1;
      end
      OpSkin: skin_q = {skin_q, blend_vertex(d)};
      default: ;
    endcase
  endfunction

  task automatic send_beat(lbs_in_t d);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk_i); while (!in_ready);
    accept_beat(d);
  endtask

  function automatic lbs_in_t mat_write(lbs_op_e op, int bone, int entry, logic [31:0] val);
    lbs_in_t d;
    d = '0;
    d.operation    = op;
    d.matrix_bone  = 6'(bone);
    d.matrix_entry = 4'(entry);
    d.matrix_value = val;
    return d;
  endfunction

  function automatic lbs_in_t skin_beat(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic [31:0] bones, logic [63:0] wts);
    lbs_in_t d;
    d = '0;
    d.operation    = OpSkin;
    d.pos_x        = x;
    d.pos_y        = y;
    d.pos_z        = z;
    d.bone_slots   = bones;
    d.slot_weights = wts;
    return d;
  endfunction

  // element value: identity, small near-unit, or full range
  function automatic logic [31:0] elem_value(int bone, int entry);
    if (bone == 0) return (entry % 5 == 0) ? 32'h0001_0000 : 32'h0;
    if ($urandom_range(9) == 0) return $urandom;
    if (entry % 5 == 0) return 32'h0001_0000 + $urandom_range(0, 32767) - 16384;
    return $urandom_range(0, 131071) - 65536;
  endfunction

  // pick a bone whose matrices are complete, else an identity code
  function automatic logic [7:0] pick_bone();
    int unsigned b;
    b = $urandom_range(0, 63);
    if ($urandom_range(9) < 7 && written[b] == 32'hFFFF_FFFF) return 8'(b);
    if ($urandom_range(1)) return BoneNone;
    return 8'($urandom_range(64, 254));
  endfunction

  function automatic lbs_in_t rand_beat();
    lbs_in_t d;
    logic [31:0] bones;
    logic [63:0] wts;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 25) return mat_write(lbs_op_e'($urandom_range(0, 1)), $urandom_range(0, 63),
                                   $urandom_range(0, 15), $urandom);
    if (sel < 28) begin
      d = lbs_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      d.operation = OpRsvd;
      return d;
    end
    for (int s = 0; s < 4; s++) bones[8*s +: 8] = pick_bone();
    if ($urandom_range(1)) wts = {$urandom, $urandom};
    else for (int s = 0; s < 4; s++) wts[16*s +: 16] = $urandom_range(0, 16384);
    if ($urandom_range(3) == 0) return skin_beat($urandom, $urandom, $urandom, bones, wts);
    return skin_beat($urandom_range(0, 20_000_000) - 10_000_000,
                     $urandom_range(0, 20_000_000) - 10_000_000,
                     $urandom_range(0, 20_000_000) - 10_000_000, bones, wts);
  endfunction

  // directed rows; has_exp marks results that can be stated outright
  typedef struct {
    lbs_in_t  beat;
    bit       has_exp;
    lbs_out_t exp;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_row(lbs_in_t d, bit he, lbs_out_t e);
    dir_row_t r;
    r.beat = d; r.has_exp = he; r.exp = e;
    dir_rows = {dir_rows, r};
  endfunction

  // result checker
  always @(posedge clk_i) begin
    lbs_out_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (skin_q.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, out_data);
        errors++;
      end else begin
        e = skin_q.pop_front();
        if (out_data.out_x !== e.out_x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.out_x, out_data.out_x);
          errors++;
        end
        if (out_data.out_y !== e.out_y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.out_y, out_data.out_y);
          errors++;
        end
        if (out_data.out_z !== e.out_z) begin
          $display("%0t: out_z expected %h actual %h", $time, e.out_z, out_data.out_z);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off at the start of the last phase
  int  hold_cnt = 0;
  bit  held = 1'b0;
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (phase == 3 && !held) begin
      held = 1'b1;
      hold_cnt = 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin
    int n;
    lbs_out_t e;
    for (int b = 0; b < NumBones; b++) written[b] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // table load: bone 0 identity, a handful of others mostly near identity
    for (int b = 0; b < 8; b++) begin
      for (int i = 0; i < 16; i++) begin
        send_beat(mat_write(OpPose, b, i, elem_value(b, i)));
        send_beat(mat_write(OpBind, b, i, elem_value(b, i)));
      end
    end

    // directed rows
    e = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000};
    add_row(skin_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFF,
                      64'h0000_0000_0000_8000), 1, e);
    e = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
    add_row(skin_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000, 32'hFFFF_FFFF,
                      64'hFFFF_FFFF_FFFF_FFFF), 1, e);
    e = '0;
    add_row(skin_beat(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      64'h0), 1, e);
    e = '{32'sh0003_0000, -32'sh0002_0000, 32'sh0000_0001};
    add_row(skin_beat(32'h0003_0000, -32'sh0002_0000, 32'h0000_0001, 32'hFFC8_40FF,
                      64'h0000_0000_0000_8000), 1, e);
    add_row(skin_beat(32'h0003_0000, -32'sh0002_0000, 32'h0000_0001, 32'hFFC8_4000,
                      64'h0000_0000_0000_8000), 1, e);
    e = '{-32'sh0001_0000, 32'sh0000_8000, 32'sh7FFF_FFFC};
    add_row(skin_beat(-32'sh0001_0000, 32'h0000_8000, 32'h7FFF_FFFF, 32'h00FF_FE00,
                      64'h2000_2000_2000_2000), 1, e);
    add_row(skin_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0403_0201,
                      64'hFFFF_FFFF_FFFF_FFFF), 0, '0);
    add_row(skin_beat(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0706_0504,
                      64'h2000_2000_2000_2000), 0, '0);
    add_row(mat_write(OpPose, 63, 15, 32'h8000_0000), 0, '0);
    add_row(mat_write(OpBind, 63, 0, 32'h7FFF_FFFF), 0, '0);
    add_row(mat_write(OpPose, 7, 15, 32'h7FFF_FFFF), 0, '0);
    add_row(mat_write(OpBind, 7, 5, 32'h8000_0000), 0, '0);
    add_row(skin_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFF07_FF07,
                      64'h0000_FFFF_0000_FFFF), 0, '0);
    add_row({OpRsvd, {4{32'hFFFF_FFFF}}, 64'hFFFF_FFFF_FFFF_FFFF, 6'h3F, 4'hF,
             32'hFFFF_FFFF}, 0, '0);
    add_row(skin_beat(32'h0, 32'h0, 32'h0, 32'h0300_0100, 64'h0000_8000_0000_8000), 0, '0);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].has_exp && blend_vertex(dir_rows[k].beat) !== dir_rows[k].exp) begin
        $display("%0t: directed row %0d expected %h actual %h", $time, k,
                 dir_rows[k].exp, blend_vertex(dir_rows[k].beat));
        errors++;
      end
      send_beat(dir_rows[k].beat);
    end

    // random stream in three idling phases
    n = 1580;
    for (int k = 0; k < n; k++) begin
      if (k == n / 3) begin
        phase = 2; tx_idle = 54; rx_idle = 9;
      end else if (k == 2 * n / 3) begin
        phase = 3; tx_idle = 0; rx_idle = 0;
      end
      send_beat(rand_beat());
    end
    in_valid <= 1'b0;

    while (skin_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
